>>> rtl/assert_macros.svh
// assertion macros for the rtl files of the oscillator block
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checking disabled while in reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checking disabled while in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/pbso_pkg.sv
// shared constants, types and fixed-point helpers of the oscillator
// no dependencies; used by the interfaces, the divider and the top level
`default_nettype none

package pbso_pkg;

   localparam int PHASE_BITS       = 32;
   localparam int SAMPLE_FRAC_BITS = 14;

   localparam int INC_W    = 32;
   localparam int AMOUNT_W = 16;
   localparam int LFO_W    = 16;
   localparam int OUT_W    = SAMPLE_FRAC_BITS + 4;
   localparam int WAVE_W   = SAMPLE_FRAC_BITS + 3;
   localparam int SUM_W    = SAMPLE_FRAC_BITS + 6;
   localparam int PW_W     = SAMPLE_FRAC_BITS + 3;
   localparam int SQ_W     = SAMPLE_FRAC_BITS + 2;
   localparam int PF_W     = PHASE_BITS + SAMPLE_FRAC_BITS;
   localparam int MAN_W    = AMOUNT_W + SAMPLE_FRAC_BITS;
   localparam int PW_SH    = 32 - SAMPLE_FRAC_BITS;
   localparam int MAN_SH   = 17;

   localparam int DOWN_SH = (PHASE_BITS >= SAMPLE_FRAC_BITS) ?
                            PHASE_BITS - SAMPLE_FRAC_BITS : 0;
   localparam int UP_SH   = (PHASE_BITS >= SAMPLE_FRAC_BITS) ?
                            0 : SAMPLE_FRAC_BITS - PHASE_BITS;

   localparam int MUL_W  = (SAMPLE_FRAC_BITS + 2 > AMOUNT_W + 1) ?
                           SAMPLE_FRAC_BITS + 2 : AMOUNT_W + 1;
   localparam int PROD_W = 2 * MUL_W;
   localparam int QCNT_W = $clog2(SAMPLE_FRAC_BITS);

   localparam longint F_ONE   = longint'(1) << SAMPLE_FRAC_BITS;
   localparam longint PW_MIN  = (F_ONE * 5 + 50) / 100;
   localparam longint PW_MAX  = (F_ONE * 95 + 50) / 100;
   localparam longint OUT_MAX = (F_ONE << 3) - 1;
   localparam longint OUT_MIN = -(F_ONE << 3);

   // register map
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_INC    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PWM_SOURCE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PWM_AMOUNT   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAW_ENABLE   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_ENABLE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUB_ENABLE   = 3'd5;

   // item operations
   localparam logic OP_SAMPLE  = 1'b0;
   localparam logic OP_NOTE_ON = 1'b1;

   // pwm source select
   localparam logic PWM_FROM_LFO    = 1'b0;
   localparam logic PWM_FROM_MANUAL = 1'b1;

   typedef struct packed {
      logic                  start;
      logic [PHASE_BITS-1:0] num;
      logic [PHASE_BITS-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                        busy;
      logic                        done;
      logic [SAMPLE_FRAC_BITS-1:0] quot;
   } div_rsp_type;

   // phase fraction to wave scale, truncating
   function automatic logic [SAMPLE_FRAC_BITS-1:0] ph_to_f(input logic [PHASE_BITS-1:0] t);
      logic [PF_W-1:0] w;
      w = PF_W'(t);
      w = (w >> DOWN_SH) << UP_SH;
      return w[SAMPLE_FRAC_BITS-1:0];
   endfunction

   // wave scale to phase fraction
   function automatic logic [PHASE_BITS-1:0] f_to_ph(input logic [SAMPLE_FRAC_BITS-1:0] x);
      logic [PF_W-1:0] w;
      w = PF_W'(x);
      w = (w << DOWN_SH) >> UP_SH;
      return w[PHASE_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/pbso_req_if.sv
// input channel of the oscillator: valid/ready with operation and lfo level
// depends on pbso_pkg for field widths
`default_nettype none

interface pbso_req_if;
   logic                             valid;
   logic                             ready;
   logic                             operation;
   logic signed [pbso_pkg::LFO_W-1:0] lfo_value;

   modport source (output valid, output operation, output lfo_value, input ready);
   modport sink   (input valid, input operation, input lfo_value, output ready);
endinterface

`default_nettype wire

>>> rtl/pbso_rsp_if.sv
// result channel of the oscillator: valid/ready with one mixed sample
// depends on pbso_pkg for the sample width
`default_nettype none

interface pbso_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [pbso_pkg::OUT_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

>>> rtl/pbso_div.sv
// iterative restoring divider: floor(num * 2^F / den) for num < den
// one quotient bit per cycle; depends on pbso_pkg
`default_nettype none

module pbso_div (
   input  logic                  clock,
   input  logic                  reset,
   input  pbso_pkg::div_req_type div_req,
   output pbso_pkg::div_rsp_type div_rsp
);

   localparam int P = pbso_pkg::PHASE_BITS;
   localparam int F = pbso_pkg::SAMPLE_FRAC_BITS;

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [pbso_pkg::QCNT_W-1:0]   cnt_ff, cnt_in;
   logic [P-1:0]                  rem_ff, rem_in;
   logic [P-1:0]                  den_ff, den_in;
   logic [F-1:0]                  quot_ff, quot_in;

   logic [P:0] rem_sh;
   logic [P:0] rem_sub;
   logic       fits;

   assign rem_sh  = {rem_ff, 1'b0};
   assign fits    = rem_sh >= {1'b0, den_ff};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = div_req.num;
         den_in  = div_req.den;
         quot_in = '0;
      end else if (busy_ff) begin
         // remainder stays below den, so the low P bits carry it
         rem_in  = fits ? rem_sub[P-1:0] : rem_sh[P-1:0];
         quot_in = {quot_ff[F-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == pbso_pkg::QCNT_W'(F - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

`default_nettype wire

>>> rtl/polyblep_saw_pulse_sub_oscillator.sv
// a sample item passes S_PROD and S_WIDTH, then one pass per corrected saw: S_TEST,
//   S_DIV and S_SQUARE only with a blep, where the bit-serial divider runs, then S_SAW
// one saw pass, two when the pulse is on, then S_MIX, which waits for the output register
// items are taken only in S_IDLE; note-on items leave it idle and give no result
// reset (synchronous, active high) clears phase, sub flip-flop, configuration registers and the sequencer
// depends on pbso_pkg, pbso_req_if, pbso_rsp_if, pbso_div and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module polyblep_saw_pulse_sub_oscillator (
   input  logic                                clock,
   input  logic                                reset,
   pbso_req_if.sink                            req_ch,
   pbso_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [pbso_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pbso_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int P = pbso_pkg::PHASE_BITS;
   localparam int F = pbso_pkg::SAMPLE_FRAC_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PROD,
      S_WIDTH,
      S_TEST,
      S_DIV,
      S_SQUARE,
      S_SAW,
      S_MIX
   } state_type;

   // sequencer and oscillator state
   state_type state_ff, state_in;
   logic [P-1:0] phase_ff, phase_in;
   logic         sub_ff, sub_in;

   // configuration registers
   logic [pbso_pkg::INC_W-1:0]    inc_ff, inc_in;
   logic                          pwm_src_ff, pwm_src_in;
   logic [pbso_pkg::AMOUNT_W-1:0] pwm_amount_ff, pwm_amount_in;
   logic                          saw_en_ff, saw_en_in;
   logic                          pulse_en_ff, pulse_en_in;
   logic                          sub_en_ff, sub_en_in;

   // per-item working registers
   logic signed [pbso_pkg::LFO_W-1:0]  lfo_ff, lfo_in;
   logic signed [pbso_pkg::PROD_W-1:0] mul_ff, mul_in;
   logic [F-1:0]                       pw_ff, pw_in;
   logic [P-1:0]                       p2_ff, p2_in;
   logic                               pass_ff, pass_in;
   logic                               blep_on_ff, blep_on_in;
   logic                               blep_neg_ff, blep_neg_in;
   logic signed [pbso_pkg::WAVE_W-1:0] saw0_ff, saw0_in;
   logic signed [pbso_pkg::WAVE_W-1:0] saw1_ff, saw1_in;

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [pbso_pkg::OUT_W-1:0] sample_ff, sample_in;

   // shared divider
   pbso_pkg::div_req_type div_req;
   pbso_pkg::div_rsp_type div_rsp;

   pbso_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   logic [P-1:0] dt;
   logic [P-1:0] t_cur;
   logic [P:0]   t_sum;
   logic         t_low;
   logic         t_high;
   logic [P-1:0] t_neg;

   assign dt     = P'(inc_ff);
   assign t_cur  = pass_ff ? p2_ff : phase_ff;
   assign t_sum  = {1'b0, t_cur} + {1'b0, dt};
   // first blep region: just after the wrap
   assign t_low  = t_cur < dt;
   // second region: the next step crosses the wrap
   assign t_high = t_sum[P] && (|t_sum[P-1:0]);
   assign t_neg  = '0 - t_cur;

   assign div_req.start = (state_ff == S_TEST) && (t_low || t_high);
   assign div_req.num   = t_low ? t_cur : t_neg;
   assign div_req.den   = dt;

   // one shared signed multiplier: amount * lfo for the width, e * e for the blep
   logic [F:0]                         e_val;
   logic signed [pbso_pkg::MUL_W-1:0]  mul_a;
   logic signed [pbso_pkg::MUL_W-1:0]  mul_b;
   logic signed [pbso_pkg::PROD_W-1:0] product;

   assign e_val = (F + 1)'(pbso_pkg::F_ONE) - {1'b0, div_rsp.quot};

   always_comb begin
      if (state_ff == S_SQUARE) begin
         mul_a = signed'(pbso_pkg::MUL_W'(e_val));
         mul_b = signed'(pbso_pkg::MUL_W'(e_val));
      end else begin
         mul_a = signed'(pbso_pkg::MUL_W'(pwm_amount_ff));
         mul_b = pbso_pkg::MUL_W'(lfo_ff);
      end
   end

   assign product = mul_a * mul_b;

   // pulse width, then clamp to the legal band
   logic [pbso_pkg::MAN_W-1:0]       man_wide;
   logic signed [pbso_pkg::PW_W-1:0] pw_lfo;
   logic signed [pbso_pkg::PW_W-1:0] pw_man;
   logic signed [pbso_pkg::PW_W-1:0] pw_raw;
   logic signed [pbso_pkg::PW_W-1:0] pw_clamp;

   assign man_wide = {pwm_amount_ff, {F{1'b0}}} >> pbso_pkg::MAN_SH;
   // arithmetic shift gives the floor of the signed product
   assign pw_lfo   = pbso_pkg::PW_W'(pbso_pkg::F_ONE / 2) +
                     pbso_pkg::PW_W'(mul_ff >>> pbso_pkg::PW_SH);
   assign pw_man   = pbso_pkg::PW_W'(pbso_pkg::F_ONE / 4) +
                     signed'(pbso_pkg::PW_W'(man_wide));
   assign pw_raw   = (pwm_src_ff == pbso_pkg::PWM_FROM_MANUAL) ? pw_man : pw_lfo;

   always_comb begin
      pw_clamp = pw_raw;
      if (pw_raw < pbso_pkg::PW_W'(pbso_pkg::PW_MIN)) begin
         pw_clamp = pbso_pkg::PW_W'(pbso_pkg::PW_MIN);
      end
      if (pw_raw > pbso_pkg::PW_W'(pbso_pkg::PW_MAX)) begin
         pw_clamp = pbso_pkg::PW_W'(pbso_pkg::PW_MAX);
      end
   end

   // offset phase of the second saw, wraps modulo one cycle
   logic [P-1:0] p2_sum;
   assign p2_sum = phase_ff + pbso_pkg::f_to_ph(pw_ff);

   // blep and corrected saw at the current phase
   logic signed [pbso_pkg::SQ_W-1:0]   sq_val;
   logic signed [pbso_pkg::SQ_W-1:0]   blep_val;
   logic signed [pbso_pkg::WAVE_W-1:0] saw_val;

   assign sq_val = pbso_pkg::SQ_W'(mul_ff >>> F);

   always_comb begin
      if (!blep_on_ff) begin
         blep_val = '0;
      end else if (blep_neg_ff) begin
         blep_val = -sq_val;
      end else begin
         blep_val = sq_val;
      end
   end

   assign saw_val = signed'(pbso_pkg::WAVE_W'({pbso_pkg::ph_to_f(t_cur), 1'b0})) -
                    pbso_pkg::WAVE_W'(pbso_pkg::F_ONE) - pbso_pkg::WAVE_W'(blep_val);

   // mixer with saturation
   logic signed [pbso_pkg::SUM_W-1:0] sum_saw;
   logic signed [pbso_pkg::SUM_W-1:0] sum_pulse;
   logic signed [pbso_pkg::SUM_W-1:0] sum_sub;
   logic signed [pbso_pkg::SUM_W-1:0] sum_all;
   logic signed [pbso_pkg::SUM_W-1:0] sum_sat;
   logic [P:0]                        phase_next;

   assign sum_saw   = saw_en_ff ? pbso_pkg::SUM_W'(saw0_ff) : '0;
   // pulse = saw(p) - saw(p + pw) + 1 - 2pw
   assign sum_pulse = pulse_en_ff ?
                      (pbso_pkg::SUM_W'(saw0_ff) - pbso_pkg::SUM_W'(saw1_ff) +
                       pbso_pkg::SUM_W'(pbso_pkg::F_ONE) -
                       signed'(pbso_pkg::SUM_W'({pw_ff, 1'b0}))) : '0;
   assign sum_sub   = !sub_en_ff ? '0 :
                      (sub_ff ? pbso_pkg::SUM_W'(pbso_pkg::F_ONE) :
                                pbso_pkg::SUM_W'(-pbso_pkg::F_ONE));
   assign sum_all   = sum_saw + sum_pulse + sum_sub;

   always_comb begin
      sum_sat = sum_all;
      if (sum_all > pbso_pkg::SUM_W'(pbso_pkg::OUT_MAX)) begin
         sum_sat = pbso_pkg::SUM_W'(pbso_pkg::OUT_MAX);
      end
      if (sum_all < pbso_pkg::SUM_W'(pbso_pkg::OUT_MIN)) begin
         sum_sat = pbso_pkg::SUM_W'(pbso_pkg::OUT_MIN);
      end
   end

   assign phase_next = {1'b0, phase_ff} + {1'b0, dt};

   // handshake
   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.sample = sample_ff;

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      sub_in        = sub_ff;
      inc_in        = inc_ff;
      pwm_src_in    = pwm_src_ff;
      pwm_amount_in = pwm_amount_ff;
      saw_en_in     = saw_en_ff;
      pulse_en_in   = pulse_en_ff;
      sub_en_in     = sub_en_ff;
      lfo_in        = lfo_ff;
      mul_in        = mul_ff;
      pw_in         = pw_ff;
      p2_in         = p2_ff;
      pass_in       = pass_ff;
      blep_on_in    = blep_on_ff;
      blep_neg_in   = blep_neg_ff;
      saw0_in       = saw0_ff;
      saw1_in       = saw1_ff;
      sample_in     = sample_ff;
      rsp_valid_in  = rsp_valid_ff;

      // output register drains independently of the sequencer
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      // the user must write registers only while idle; the block does not enforce it
      if (csr_we) begin
         case (csr_index)
            pbso_pkg::CSR_PHASE_INC: begin
               inc_in = csr_wdata[pbso_pkg::INC_W-1:0];
            end
            pbso_pkg::CSR_PWM_SOURCE: begin
               pwm_src_in = csr_wdata[0];
            end
            pbso_pkg::CSR_PWM_AMOUNT: begin
               pwm_amount_in = csr_wdata[pbso_pkg::AMOUNT_W-1:0];
            end
            pbso_pkg::CSR_SAW_ENABLE: begin
               saw_en_in = csr_wdata[0];
            end
            pbso_pkg::CSR_PULSE_ENABLE: begin
               pulse_en_in = csr_wdata[0];
            end
            pbso_pkg::CSR_SUB_ENABLE: begin
               sub_en_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.operation == pbso_pkg::OP_NOTE_ON) begin
                  // note on: restart the sub square low, phase kept
                  sub_in = 1'b0;
               end else begin
                  lfo_in   = req_ch.lfo_value;
                  pass_in  = 1'b0;
                  state_in = S_PROD;
               end
            end
         end
         S_PROD: begin
            mul_in   = product;
            state_in = S_WIDTH;
         end
         S_WIDTH: begin
            pw_in    = pw_clamp[F-1:0];
            state_in = S_TEST;
         end
         S_TEST: begin
            if (!pass_ff) begin
               p2_in = p2_sum;
            end
            blep_on_in  = t_low || t_high;
            blep_neg_in = t_low;
            // divider is started from this state when a blep applies
            state_in    = (t_low || t_high) ? S_DIV : S_SAW;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            mul_in   = product;
            state_in = S_SAW;
         end
         S_SAW: begin
            if (!pass_ff) begin
               saw0_in = saw_val;
               if (pulse_en_ff) begin
                  pass_in  = 1'b1;
                  state_in = S_TEST;
               end else begin
                  state_in = S_MIX;
               end
            end else begin
               saw1_in  = saw_val;
               state_in = S_MIX;
            end
         end
         S_MIX: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               sample_in    = sum_sat[pbso_pkg::OUT_W-1:0];
               rsp_valid_in = 1'b1;
               phase_in     = phase_next[P-1:0];
               if (phase_next[P]) begin
                  sub_in = !sub_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= '0;
         sub_ff        <= 1'b0;
         inc_ff        <= '0;
         pwm_src_ff    <= pbso_pkg::PWM_FROM_LFO;
         pwm_amount_ff <= '0;
         saw_en_ff     <= 1'b0;
         pulse_en_ff   <= 1'b0;
         sub_en_ff     <= 1'b0;
         pass_ff       <= 1'b0;
         blep_on_ff    <= 1'b0;
         blep_neg_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         sub_ff        <= sub_in;
         inc_ff        <= inc_in;
         pwm_src_ff    <= pwm_src_in;
         pwm_amount_ff <= pwm_amount_in;
         saw_en_ff     <= saw_en_in;
         pulse_en_ff   <= pulse_en_in;
         sub_en_ff     <= sub_en_in;
         pass_ff       <= pass_in;
         blep_on_ff    <= blep_on_in;
         blep_neg_ff   <= blep_neg_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      lfo_in_hold: begin
      end
      lfo_ff    <= lfo_in;
      mul_ff    <= mul_in;
      pw_ff     <= pw_in;
      p2_ff     <= p2_in;
      saw0_ff   <= saw0_in;
      saw1_ff   <= saw1_in;
      sample_ff <= sample_in;
   end

   // divider only runs while the sequencer waits on it
   `ASSERT_IMPLIES(a_div_owned, clock, reset, div_rsp.busy, state_ff == S_DIV, "divider busy outside wait state")
   // a new result only comes out of the mix step
   `ASSERT_IMPLIES(a_rsp_from_mix, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_MIX), "result raised outside mix")
   // phase advances only when a sample is mixed
   `ASSERT_NEXT(a_phase_hold, clock, reset, state_ff != S_MIX, $stable(phase_ff), "phase moved without a sample")
   // clamped width stays inside its band once registered
   `ASSERT_IMPLIES(a_pw_band, clock, reset, state_ff == S_TEST, (pw_ff >= F'(pbso_pkg::PW_MIN)) && (pw_ff <= F'(pbso_pkg::PW_MAX)), "pulse width outside clamp band")

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
// self-checking bench for the polyblep saw, pulse and sub oscillator
// depends on pbso_pkg, pbso_req_if, pbso_rsp_if and the oscillator top level

module tb;
   import pbso_pkg::*;

   typedef longint unsigned u64_t;

   // timing of the run
   localparam int RESET_CYCLES    = 12;
   localparam int SETTLE_CYCLES   = 48;      // covers the slowest sample, two saw passes with a blep each
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int END_WAIT        = 20000;
   localparam int LONG_HOLD       = 400;
   localparam int MAX_REPORTS     = 40;

   // shape of the random part
   localparam int RANDOM_PHASES   = 12;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int PAUSE_PHASE     = 4;
   localparam int HOLD_PHASE      = 6;

   // register indexes that map to nothing, writes there must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam u64_t PH_CYCLE = u64_t'(1) << PHASE_BITS;

   // one line of the directed table, either a register write or an item
   typedef struct {
      bit                          is_cfg;
      logic [CSR_INDEX_W-1:0]      index;
      logic [CSR_DATA_W-1:0]       data;
      logic                        op;
      logic signed [LFO_W-1:0]     lfo;
      bit                          pinned;   // expected sample typed into the table
      logic signed [OUT_W-1:0]     want;
   } plan_row_t;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   pbso_req_if req_ch();
   pbso_rsp_if rsp_ch();

   polyblep_saw_pulse_sub_oscillator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // oscillator state and registers as the bench sees them
   logic [PHASE_BITS-1:0] osc_phase;
   logic                  sub_square;
   logic [INC_W-1:0]      phase_step;
   logic                  pw_manual;
   logic [AMOUNT_W-1:0]   pw_amount;
   logic                  saw_on;
   logic                  pulse_on;
   logic                  sub_on;

   logic signed [OUT_W-1:0] expected_samples[$];
   logic signed [OUT_W-1:0] oldest_sample;
   plan_row_t               directed_plan[$];

   int cycle_count = 0;
   int mismatch_count = 0;
   bit tx_idle_on;
   bit rx_idle_on;
   bit long_hold_req;

   // floor(num * 2^F / den) by restoring division, num < den
   function automatic u64_t frac_quot(u64_t num, u64_t den);
      u64_t q;
      u64_t r;
      q = 0;
      r = num;
      for (int i = 0; i < SAMPLE_FRAC_BITS; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 1;
         end
      end
      return q;
   endfunction

   // polyblep residual at phase t for step dt, the start-of-cycle test wins
   function automatic longint blep_term(u64_t t, u64_t dt);
      u64_t e;
      if (t < dt) begin
         e = u64_t'(F_ONE) - frac_quot(t, dt);
         return -longint'((e * e) >> SAMPLE_FRAC_BITS);
      end
      if (t + dt > PH_CYCLE) begin
         e = u64_t'(F_ONE) - frac_quot(PH_CYCLE - t, dt);
         return longint'((e * e) >> SAMPLE_FRAC_BITS);
      end
      return 0;
   endfunction

   // corrected saw 2p - 1 - blep at wave scale
   function automatic longint saw_level(u64_t t, u64_t dt);
      return 2 * longint'((t >> DOWN_SH) << UP_SH) - F_ONE - blep_term(t, dt);
   endfunction

   // mixed sample for one item, then the phase advances and the sub may toggle
   function automatic logic signed [OUT_W-1:0] next_sample(logic signed [LFO_W-1:0] lfo);
      u64_t   dt;
      u64_t   ph;
      u64_t   ph2;
      u64_t   nxt;
      u64_t   width_ph;
      longint width;
      longint total;
      dt = u64_t'(phase_step) % PH_CYCLE;
      ph = u64_t'(osc_phase);
      if (pw_manual == PWM_FROM_LFO)
         width = F_ONE / 2 + ((longint'(pw_amount) * longint'(lfo)) >>> PW_SH);
      else
         width = F_ONE / 4 + ((longint'(pw_amount) << SAMPLE_FRAC_BITS) >>> MAN_SH);
      if (width < PW_MIN) width = PW_MIN;
      if (width > PW_MAX) width = PW_MAX;
      total = 0;
      if (saw_on)
         total += saw_level(ph, dt);
      if (pulse_on) begin
         width_ph = (u64_t'(width) << DOWN_SH) >> UP_SH;
         ph2 = (ph + width_ph) % PH_CYCLE;
         total += saw_level(ph, dt) - saw_level(ph2, dt) + F_ONE - 2 * width;
      end
      if (sub_on)
         total += sub_square ? F_ONE : -F_ONE;
      if (total > OUT_MAX) total = OUT_MAX;
      if (total < OUT_MIN) total = OUT_MIN;
      nxt = ph + dt;
      if (nxt >= PH_CYCLE)
         sub_square = ~sub_square;
      osc_phase = nxt[PHASE_BITS-1:0];
      return total[OUT_W-1:0];
   endfunction

   function automatic plan_row_t cfg_row(logic [CSR_INDEX_W-1:0] idx,
                                         logic [CSR_DATA_W-1:0] data);
      plan_row_t row;
      row = '{is_cfg: 1'b1, index: idx, data: data, op: OP_SAMPLE, lfo: '0,
              pinned: 1'b0, want: '0};
      return row;
   endfunction

   function automatic plan_row_t item_row(logic op, logic signed [LFO_W-1:0] lfo,
                                          bit pinned, logic signed [OUT_W-1:0] want);
      plan_row_t row;
      row = '{is_cfg: 1'b0, index: CSR_PHASE_INC, data: '0, op: op, lfo: lfo,
              pinned: pinned, want: want};
      return row;
   endfunction

   task automatic report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   // offer one item, wait for its handshake and queue what it should give
   // entered right after a rising edge, returns at the edge that accepted it
   task automatic send_item(logic op, logic signed [LFO_W-1:0] lfo,
                            bit pinned, logic signed [OUT_W-1:0] want);
      int gap;
      logic signed [OUT_W-1:0] predicted;
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.lfo_value <= lfo;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      if (op == OP_NOTE_ON) begin
         // note on only clears the sub square, phase is kept
         sub_square = 1'b0;
      end else begin
         predicted = next_sample(lfo);
         expected_samples.push_back(pinned ? want : predicted);
      end
   endtask

   // one register write, the bench copy follows with the same masking
   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_PHASE_INC:    phase_step = data[INC_W-1:0];
         CSR_PWM_SOURCE:   pw_manual  = data[0];
         CSR_PWM_AMOUNT:   pw_amount  = data[AMOUNT_W-1:0];
         CSR_SAW_ENABLE:   saw_on     = data[0];
         CSR_PULSE_ENABLE: pulse_on   = data[0];
         CSR_SUB_ENABLE:   sub_on     = data[0];
         default: ;
      endcase
   endtask

   // stop offering, let every sample come back, then cover a trailing note on
   task automatic drain_block();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register settings of one random phase, the first three are extremes
   task automatic random_settings(int phase_no);
      logic [INC_W-1:0]    inc;
      logic [AMOUNT_W-1:0] amt;
      logic [2:0]          waves;
      logic                src;
      case (phase_no)
         0: begin
            inc = 32'h8000_0000; src = PWM_FROM_LFO; amt = 16'hFFFF; waves = 3'b111;
         end
         1: begin
            inc = 32'd1; src = PWM_FROM_MANUAL; amt = 16'h0000; waves = 3'b111;
         end
         2: begin
            inc = 32'd0; src = PWM_FROM_MANUAL; amt = 16'hFFFF; waves = 3'b111;
         end
         default: begin
            case ($urandom_range(0, 5))
               0: inc = $urandom_range(1, 1 << 16);
               1: inc = $urandom_range(1 << 20, 1 << 26);
               2: inc = $urandom_range(1 << 24, 1 << 28);
               3: inc = 32'h8000_0000 - $urandom_range(0, 3);
               4: inc = $urandom_range(0, 32'h8000_0000);
               default: inc = $urandom_range(1 << 28, 32'h8000_0000);
            endcase
            src = $urandom_range(0, 1);
            case ($urandom_range(0, 3))
               0: amt = 16'h0000;
               1: amt = 16'hFFFF;
               default: amt = AMOUNT_W'($urandom);
            endcase
            waves = 3'($urandom);
         end
      endcase
      // upper data bits are random, only the register width counts
      csr_write(CSR_PHASE_INC, inc);
      csr_write(CSR_PWM_SOURCE, ($urandom & 32'hFFFF_FFFE) | 32'(src));
      csr_write(CSR_PWM_AMOUNT, {16'($urandom), amt});
      csr_write(CSR_SAW_ENABLE, ($urandom & 32'hFFFF_FFFE) | 32'(waves[0]));
      csr_write(CSR_PULSE_ENABLE, ($urandom & 32'hFFFF_FFFE) | 32'(waves[1]));
      csr_write(CSR_SUB_ENABLE, ($urandom & 32'hFFFF_FFFE) | 32'(waves[2]));
      if ($urandom_range(0, 2) == 0)
         csr_write($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, $urandom);
      csr_we <= 1'b0;
   endtask

   // receiver: random stall bursts plus one long hold-off on request
   initial begin
      int hold_left;
      int stall_left;
      hold_left  = 0;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            hold_left     = LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            // start a stall burst, its remaining length drawn at random
            stall_left = $urandom_range(0, 8);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // every delivered sample against the oldest one still owed
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_samples.size() == 0) begin
            report_mismatch($sformatf("sample %0d with none expected", rsp_ch.sample));
         end else begin
            oldest_sample = expected_samples.pop_front();
            if (rsp_ch.sample !== oldest_sample)
               report_mismatch($sformatf("sample got %0d want %0d",
                                         rsp_ch.sample, oldest_sample));
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      logic                    op;
      logic signed [LFO_W-1:0] lfo;
      int                      waited;

      // every input known from time zero, reset held
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.operation <= OP_SAMPLE;
      req_ch.lfo_value <= '0;
      csr_we           <= 1'b0;
      csr_index        <= CSR_PHASE_INC;
      csr_wdata        <= '0;

      osc_phase     = '0;
      sub_square    = 1'b0;
      phase_step    = '0;
      pw_manual     = PWM_FROM_LFO;
      pw_amount     = '0;
      saw_on        = 1'b0;
      pulse_on      = 1'b0;
      sub_on        = 1'b0;
      tx_idle_on    = 1'b1;
      rx_idle_on    = 1'b1;
      long_hold_req = 1'b0;

      // directed table, pinned rows are read straight off the fixed-point rules
      // after reset everything is off and the increment is zero
      directed_plan.push_back(item_row(OP_SAMPLE, 16'sh0000, 1'b1, '0));
      // sub alone, square starts low; upper write bits must be dropped
      directed_plan.push_back(cfg_row(CSR_SUB_ENABLE, 32'hFFFF_FFFF));
      directed_plan.push_back(item_row(OP_SAMPLE, 16'sh0000, 1'b1, OUT_W'(-F_ONE)));
      // naive saw at phase zero adds -1
      directed_plan.push_back(cfg_row(CSR_SAW_ENABLE, 32'd1));
      directed_plan.push_back(item_row(OP_SAMPLE, 16'sh7FFF, 1'b1, OUT_W'(-2 * F_ONE)));
      // pulse at half width with zero depth adds another -1
      directed_plan.push_back(cfg_row(CSR_PULSE_ENABLE, 32'hABCD_0001));
      directed_plan.push_back(item_row(OP_SAMPLE, 16'sh8000, 1'b1, OUT_W'(-3 * F_ONE)));
      // full depth drives the width into both clamps
      directed_plan.push_back(cfg_row(CSR_PWM_AMOUNT, 32'h0000_FFFF));
      directed_plan.push_back(item_row(OP_SAMPLE, 16'sh7FFF, 1'b0, '0));
      directed_plan.push_back(item_row(OP_SAMPLE, 16'sh8000, 1'b0, '0));
      directed_plan.push_back(cfg_row(CSR_PWM_SOURCE, 32'(PWM_FROM_MANUAL)));
      directed_plan.push_back(item_row(OP_SAMPLE, 16'sh0000, 1'b0, '0));
      // half-cycle step wraps every other sample
      directed_plan.push_back(cfg_row(CSR_PHASE_INC, 32'h8000_0000));
      directed_plan.push_back(item_row(OP_SAMPLE, 16'sh0001, 1'b0, '0));
      directed_plan.push_back(item_row(OP_SAMPLE, 16'shFFFF, 1'b0, '0));
      directed_plan.push_back(item_row(OP_SAMPLE, 16'sh4000, 1'b0, '0));
      directed_plan.push_back(item_row(OP_SAMPLE, 16'shC000, 1'b0, '0));
      // note on mid-cycle clears the square and keeps the phase
      directed_plan.push_back(item_row(OP_NOTE_ON, 16'sh1234, 1'b0, '0));
      directed_plan.push_back(item_row(OP_SAMPLE, 16'sh0000, 1'b0, '0));
      directed_plan.push_back(item_row(OP_SAMPLE, 16'sh0000, 1'b0, '0));
      // smallest step
      directed_plan.push_back(cfg_row(CSR_PHASE_INC, 32'd1));
      directed_plan.push_back(item_row(OP_SAMPLE, 16'sh2000, 1'b0, '0));
      directed_plan.push_back(item_row(OP_SAMPLE, 16'shE000, 1'b0, '0));
      // just under half a cycle, back to lfo width
      directed_plan.push_back(cfg_row(CSR_PWM_SOURCE, 32'(PWM_FROM_LFO)));
      directed_plan.push_back(cfg_row(CSR_PHASE_INC, 32'h7FFF_FFFF));
      directed_plan.push_back(item_row(OP_SAMPLE, 16'sh7FFF, 1'b0, '0));
      directed_plan.push_back(item_row(OP_SAMPLE, 16'sh8000, 1'b0, '0));
      directed_plan.push_back(item_row(OP_SAMPLE, 16'sh0000, 1'b0, '0));
      // unmapped index is ignored, then zero step gives naive waves
      directed_plan.push_back(cfg_row(CSR_SPARE_LO, 32'hFFFF_FFFF));
      directed_plan.push_back(cfg_row(CSR_SPARE_HI, 32'hFFFF_FFFF));
      directed_plan.push_back(cfg_row(CSR_PHASE_INC, 32'd0));
      directed_plan.push_back(item_row(OP_SAMPLE, 16'sh5555, 1'b0, '0));
      directed_plan.push_back(item_row(OP_SAMPLE, 16'shAAAA, 1'b0, '0));
      directed_plan.push_back(item_row(OP_NOTE_ON, 16'shFFFF, 1'b0, '0));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the table, register rows only once the block is idle
      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_cfg) begin
            if (i == 0 || !directed_plan[i-1].is_cfg)
               drain_block();
            csr_write(directed_plan[i].index, directed_plan[i].data);
         end else begin
            csr_we <= 1'b0;
            send_item(directed_plan[i].op, directed_plan[i].lfo,
                      directed_plan[i].pinned, directed_plan[i].want);
         end
      end

      // random phases, each with its own register setting
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         // last phase runs flat out on both sides
         if (ph == RANDOM_PHASES - 1) begin
            tx_idle_on = 1'b0;
            rx_idle_on = 1'b0;
         end
         drain_block();
         random_settings(ph);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // receiver holds off while items keep coming, the block backs up
            if (ph == HOLD_PHASE && n == 20)
               long_hold_req = 1'b1;
            // sender waits for every owed sample before going on
            if (ph == PAUSE_PHASE && n == 60) begin
               req_ch.valid <= 1'b0;
               @(posedge clock);
               while (expected_samples.size() != 0) @(posedge clock);
            end
            op = ($urandom_range(0, 19) == 0) ? OP_NOTE_ON : OP_SAMPLE;
            case ($urandom_range(0, 7))
               0: lfo = 16'sh7FFF;
               1: lfo = 16'sh8000;
               2: lfo = 16'sh0000;
               default: lfo = LFO_W'($urandom);
            endcase
            send_item(op, lfo, 1'b0, '0);
         end
      end

      // wait out the tail
      req_ch.valid <= 1'b0;
      waited = 0;
      while (expected_samples.size() != 0 && waited < END_WAIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_samples.size() != 0)
         report_mismatch($sformatf("%0d samples never delivered", expected_samples.size()));

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> polyblep_saw_pulse_sub_oscillator.f
+incdir+rtl
rtl/pbso_pkg.sv
rtl/pbso_req_if.sv
rtl/pbso_rsp_if.sv
rtl/pbso_div.sv
rtl/polyblep_saw_pulse_sub_oscillator.sv
sim/tb.sv
